// ===== sv/sads_pkg.sv =====
// shared constants, register indexes and pipeline control type for the stick axis scaler
// no dependencies
`default_nettype none

package sads_pkg;

  localparam int unsigned ADC_BITS     = 12;
  localparam int unsigned DZ_BITS      = 7;
  localparam int unsigned PCT_BITS     = 8;
  localparam int unsigned QUO_BITS     = 8;
  localparam int unsigned CFG_IDX_BITS = 3;
  localparam int unsigned FULL_SCALE   = 100;

  localparam logic [CFG_IDX_BITS-1:0] REG_MINIMUM  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CENTER   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAXIMUM  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_DEADZONE = 3'd3;

  typedef struct packed {
    logic                valid;
    logic                zero;
    logic                neg;
    logic [QUO_BITS-1:0] quo;
  } ctl_t;

endpackage

`default_nettype wire

// ===== sv/sads_if.sv =====
// valid/ready channel interfaces: sample input, percent result, register writes
// depends on sads_pkg
`default_nettype none

interface sads_sample_if #(
  parameter int unsigned AdcBits = sads_pkg::ADC_BITS
);
  logic               valid;
  logic               ready;
  logic [AdcBits-1:0] raw_sample;

  modport source (output valid, output raw_sample, input ready);
  modport sink (input valid, input raw_sample, output ready);
endinterface

interface sads_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [sads_pkg::PCT_BITS-1:0] axis_percent;

  modport source (output valid, output axis_percent, input ready);
  modport sink (input valid, input axis_percent, output ready);
endinterface

interface sads_cfg_if #(
  parameter int unsigned AdcBits = sads_pkg::ADC_BITS
);
  logic                                 valid;
  logic                                 ready;
  logic [sads_pkg::CFG_IDX_BITS-1:0]     index;
  logic [AdcBits-1:0]                   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/sads_prep.sv =====
// front cell: side select, offset, span, deadzone test and dividend setup
// depends on sads_pkg
`default_nettype none

module sads_prep #(
  parameter int unsigned AdcBits = sads_pkg::ADC_BITS
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           en_i,
  input  wire logic                           in_valid_i,
  input  wire logic [AdcBits-1:0]             raw_sample_i,
  input  wire logic [AdcBits-1:0]             minimum_i,
  input  wire logic [AdcBits-1:0]             center_i,
  input  wire logic [AdcBits-1:0]             maximum_i,
  input  wire logic [sads_pkg::DZ_BITS-1:0]   deadzone_i,
  output sads_pkg::ctl_t                      ctl_o,
  output logic [AdcBits+7:0]                  rem_o,
  output logic [AdcBits:0]                    div_o
);

  localparam int unsigned ProdW = AdcBits + sads_pkg::DZ_BITS;
  localparam int unsigned NumW  = AdcBits + 8;

  logic               cal_ok;
  logic               above;
  logic [AdcBits-1:0] offset;
  logic [AdcBits-1:0] span;
  logic [ProdW-1:0]   dz_lhs;
  logic [ProdW-1:0]   dz_rhs;
  logic [NumW-1:0]    num;

  sads_pkg::ctl_t     ctl_d, ctl_q;
  logic [NumW-1:0]    rem_d, rem_q;
  logic [AdcBits:0]   div_d, div_q;

  always_comb begin
    cal_ok = (maximum_i > center_i) && (center_i > minimum_i);
    above  = raw_sample_i > center_i;
    offset = above ? (raw_sample_i - center_i) : (center_i - raw_sample_i);
    span   = above ? (maximum_i - center_i) : (center_i - minimum_i);
    dz_lhs = ProdW'(offset) * ProdW'(sads_pkg::FULL_SCALE);
    dz_rhs = ProdW'(maximum_i - minimum_i) * ProdW'(deadzone_i);
    num    = NumW'(offset) * NumW'(2 * sads_pkg::FULL_SCALE) + NumW'(span);

    ctl_d.valid = in_valid_i;
    ctl_d.zero  = !cal_ok || (dz_lhs <= dz_rhs);
    ctl_d.neg   = !above;
    ctl_d.quo   = '0;
    rem_d       = num;
    div_d       = {span, 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      div_q <= div_d;
    end
  end

  assign ctl_o = ctl_q;
  assign rem_o = rem_q;
  assign div_o = div_q;

endmodule

`default_nettype wire

// ===== sv/sads_cell.sv =====
// divider cell: one restoring quotient bit per cell, passes remainder to its neighbor
// depends on sads_pkg
`default_nettype none

module sads_cell #(
  parameter int unsigned AdcBits = sads_pkg::ADC_BITS,
  parameter int unsigned Shift   = 0
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire sads_pkg::ctl_t       ctl_i,
  input  wire logic [AdcBits+7:0]   rem_i,
  input  wire logic [AdcBits:0]     div_i,
  output sads_pkg::ctl_t            ctl_o,
  output logic [AdcBits+7:0]        rem_o,
  output logic [AdcBits:0]          div_o
);

  localparam int unsigned RemW = AdcBits + 8;

  logic [RemW-1:0]  dsh;
  logic [RemW:0]    diff;
  logic             fits;

  sads_pkg::ctl_t   ctl_d, ctl_q;
  logic [RemW-1:0]  rem_d, rem_q;
  logic [AdcBits:0] div_q;

  always_comb begin
    dsh   = RemW'(div_i) << Shift;
    diff  = {1'b0, rem_i} - {1'b0, dsh};
    fits  = !diff[RemW];
    ctl_d = ctl_i;
    if (fits) begin
      ctl_d.quo[Shift] = 1'b1;
    end
    rem_d = fits ? diff[RemW-1:0] : rem_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      div_q <= div_i;
    end
  end

  assign ctl_o = ctl_q;
  assign rem_o = rem_q;
  assign div_o = div_q;

endmodule

`default_nettype wire

// ===== sv/stick_axis_deadzone_scaler.sv =====
// top level: calibration registers, front cell, divider cell chain, output register
// depends on sads_pkg, sads_if, sads_prep, sads_cell
//
// usage
//   sample_i carries one raw adc reading per item, result_o one signed percent
//   (-100..100, two's complement) per item, in order. cfg_i writes the
//   calibration registers: index 0 minimum, 1 center, 2 maximum, 3 deadzone
//   percent; other indexes are dropped. cfg_i is always ready; write only
//   while no item is in flight.
//   each item passes through one front cell, eight divider cells (one quotient bit
//   each) and the output register.
//   throughput is one item per cycle unless stalled; the whole chain moves together.
//   when the receiver stalls with a result waiting, the chain freezes and
//   sample_i.ready drops in the same cycle; it returns as soon as the
//   result is taken. sample_i.ready does not wait on the chain being empty.
//   reset empties the chain and loads minimum 0, center 2048 and maximum
//   4095 (both masked to the adc width) and deadzone 0.
`default_nettype none

module stick_axis_deadzone_scaler #(
  parameter int unsigned AdcBits = sads_pkg::ADC_BITS
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  sads_sample_if.sink   sample_i,
  sads_cfg_if.sink      cfg_i,
  sads_result_if.source result_o
);

  localparam int unsigned QuoBits    = sads_pkg::QUO_BITS;
  localparam int unsigned PctBits    = sads_pkg::PCT_BITS;
  localparam int unsigned MagBits    = PctBits - 1;
  localparam int unsigned CenterRst  = 2048 % (1 << AdcBits);
  localparam int unsigned MaximumRst = 4095 % (1 << AdcBits);

  logic [AdcBits-1:0]              minimum_q;
  logic [AdcBits-1:0]              center_q;
  logic [AdcBits-1:0]              maximum_q;
  logic [sads_pkg::DZ_BITS-1:0]    deadzone_q;

  logic                            adv;
  sads_pkg::ctl_t                  ctl_chain [QuoBits+1];
  logic [AdcBits+7:0]              rem_chain [QuoBits+1];
  logic [AdcBits:0]                div_chain [QuoBits+1];

  sads_pkg::ctl_t                  last;
  logic [MagBits-1:0]              quo_lo;
  logic [MagBits-1:0]              mag;
  logic [PctBits-1:0]              pct_d, pct_q;
  logic                            out_valid_q;

  // calibration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      minimum_q  <= '0;
      center_q   <= AdcBits'(CenterRst);
      maximum_q  <= AdcBits'(MaximumRst);
      deadzone_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        sads_pkg::REG_MINIMUM:  minimum_q  <= cfg_i.data;
        sads_pkg::REG_CENTER:   center_q   <= cfg_i.data;
        sads_pkg::REG_MAXIMUM:  maximum_q  <= cfg_i.data;
        sads_pkg::REG_DEADZONE: deadzone_q <= cfg_i.data[sads_pkg::DZ_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_i.ready    = 1'b1;
  assign adv            = !out_valid_q || result_o.ready;
  assign sample_i.ready = adv;

  sads_prep #(
    .AdcBits (AdcBits)
  ) u_prep (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (adv),
    .in_valid_i   (sample_i.valid),
    .raw_sample_i (sample_i.raw_sample),
    .minimum_i    (minimum_q),
    .center_i     (center_q),
    .maximum_i    (maximum_q),
    .deadzone_i   (deadzone_q),
    .ctl_o        (ctl_chain[0]),
    .rem_o        (rem_chain[0]),
    .div_o        (div_chain[0])
  );

  for (genvar g = 0; g < QuoBits; g++) begin : g_cell
    sads_cell #(
      .AdcBits (AdcBits),
      .Shift   (QuoBits - 1 - g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .ctl_i  (ctl_chain[g]),
      .rem_i  (rem_chain[g]),
      .div_i  (div_chain[g]),
      .ctl_o  (ctl_chain[g+1]),
      .rem_o  (rem_chain[g+1]),
      .div_o  (div_chain[g+1])
    );
  end

  // saturate and apply sign
  always_comb begin
    last   = ctl_chain[QuoBits];
    quo_lo = last.quo[MagBits-1:0];
    if (last.quo[QuoBits-1] || (quo_lo > MagBits'(sads_pkg::FULL_SCALE))) begin
      mag = MagBits'(sads_pkg::FULL_SCALE);
    end else begin
      mag = quo_lo;
    end
    if (last.zero) begin
      pct_d = '0;
    end else if (last.neg) begin
      pct_d = -{1'b0, mag};
    end else begin
      pct_d = {1'b0, mag};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pct_q <= pct_d;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.axis_percent = pct_q;

endmodule

`default_nettype wire

// ===== sv/sads_checker.sv =====
// port-level checks for the stick axis scaler, bound to the top level
// depends on stick_axis_deadzone_scaler ports
`default_nettype none

module sads_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            in_ready_i,
  input wire logic                            out_valid_i,
  input wire logic                            out_ready_i,
  input wire logic [sads_pkg::PCT_BITS-1:0]   out_percent_i
);

  // result held while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_percent_i))
    else $error("result dropped or changed while stalled");

  // result stays in the legal percent range
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ($signed(out_percent_i) <= 100) && ($signed(out_percent_i) >= -100))
    else $error("percent out of range");

  // a stalled result freezes intake
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("sample taken while result stalled");

  // an empty output register never blocks intake
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("intake blocked with no result waiting");

endmodule

bind stick_axis_deadzone_scaler sads_checker u_sads_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (sample_i.ready),
  .out_valid_i   (result_o.valid),
  .out_ready_i   (result_o.ready),
  .out_percent_i (result_o.axis_percent)
);

`default_nettype wire

// ===== bench/axis_percent_checker.sv =====
`timescale 1ns / 100ps
// axis percent checker: watches the sample, register write and result channels of the scaler,
// predicts each percent from the calibration it has seen and compares results in order
// depends on sads_pkg
module axis_percent_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 sample_valid_i,
  input  logic                                 sample_ready_i,
  input  logic [sads_pkg::ADC_BITS-1:0]        raw_sample_i,
  input  logic                                 cfg_valid_i,
  input  logic                                 cfg_ready_i,
  input  logic [sads_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [sads_pkg::ADC_BITS-1:0]        cfg_data_i,
  input  logic                                 result_valid_i,
  input  logic                                 result_ready_i,
  input  logic signed [sads_pkg::PCT_BITS-1:0] axis_percent_i,
  output int                                   pending_o,
  output int                                   fail_count_o
);

  localparam int ADC_W = sads_pkg::ADC_BITS;
  localparam int DZ_W  = sads_pkg::DZ_BITS;
  localparam int PCT_W = sads_pkg::PCT_BITS;

  typedef struct {
    logic [ADC_W-1:0]        raw;
    logic signed [PCT_W-1:0] percent;
  } percent_due_t;

  percent_due_t     percent_due[$];
  percent_due_t     oldest;
  logic [ADC_W-1:0] cal_min;
  logic [ADC_W-1:0] cal_center;
  logic [ADC_W-1:0] cal_max;
  logic [DZ_W-1:0]  cal_deadzone;
  int               mismatches;

  function automatic logic signed [PCT_W-1:0] percent_of_sample(
    input logic [ADC_W-1:0] raw,
    input logic [ADC_W-1:0] lo,
    input logic [ADC_W-1:0] mid,
    input logic [ADC_W-1:0] hi,
    input logic [DZ_W-1:0]  dz
  );
    int unsigned      offset;
    int unsigned      span;
    int unsigned      full_range;
    int unsigned      mag;
    logic             above;
    logic [PCT_W-1:0] pct;
    if (hi <= mid || mid <= lo) begin
      return '0;
    end
    above      = raw > mid;
    offset     = above ? raw - mid : mid - raw;
    span       = above ? hi - mid : mid - lo;
    full_range = hi - lo;
    if (sads_pkg::FULL_SCALE * offset <= full_range * dz) begin
      return '0;
    end
    // round half away from zero of 100 * offset / span
    mag = (2 * sads_pkg::FULL_SCALE * offset + span) / (2 * span);
    if (mag > sads_pkg::FULL_SCALE) begin
      mag = sads_pkg::FULL_SCALE;
    end
    pct = mag[PCT_W-1:0];
    return above ? pct : -pct;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_min      = '0;
      cal_center   = ADC_W'(2048);
      cal_max      = '1;
      cal_deadzone = '0;
      percent_due.delete();
      mismatches   = 0;
    end else begin
      if (result_valid_i && result_ready_i) begin
        if (percent_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result %0d with no item outstanding", $realtime, axis_percent_i);
          end
        end else begin
          oldest = percent_due.pop_front();
          if (axis_percent_i !== oldest.percent) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: raw %0d axis_percent expected %0d got %0d", $realtime,
                       oldest.raw, oldest.percent, axis_percent_i);
            end
          end
        end
      end
      if (sample_valid_i && sample_ready_i) begin
        percent_due.push_back('{raw_sample_i,
          percent_of_sample(raw_sample_i, cal_min, cal_center, cal_max, cal_deadzone)});
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          sads_pkg::REG_MINIMUM:  cal_min = cfg_data_i;
          sads_pkg::REG_CENTER:   cal_center = cfg_data_i;
          sads_pkg::REG_MAXIMUM:  cal_max = cfg_data_i;
          sads_pkg::REG_DEADZONE: cal_deadzone = cfg_data_i[DZ_W-1:0];
          default: ;
        endcase
      end
    end
    pending_o    = percent_due.size();
    fail_count_o = mismatches;
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// testbench top for stick_axis_deadzone_scaler: clock, reset, calibration writes,
// sample stimulus with random gaps and receiver stalls, and the verdict
// depends on sads_pkg, sads_if, the scaler rtl and axis_percent_checker
module testbench;

  localparam int ADC_W            = sads_pkg::ADC_BITS;
  localparam int IDX_W            = sads_pkg::CFG_IDX_BITS;
  localparam int ADC_TOP          = 2 ** ADC_W - 1;
  localparam int DRAIN_CYCLES     = 14;
  localparam int PHASES           = 10;
  localparam int PHASE_ITEMS      = 125;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int UNUSED_INDEXES   = 2 ** IDX_W - sads_pkg::REG_DEADZONE - 1;

  logic             clk;
  logic             rst_n;
  logic             long_hold;
  logic             rx_steady;
  logic             tx_steady;
  int               pending;
  int               fail_count;
  int               cal_count;
  logic [ADC_W-1:0] burst_raws[$];
  logic [ADC_W-1:0] cur_lo;
  logic [ADC_W-1:0] cur_mid;
  logic [ADC_W-1:0] cur_hi;

  sads_sample_if sample_if ();
  sads_cfg_if    cfg_if ();
  sads_result_if result_if ();

  stick_axis_deadzone_scaler dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .sample_i (sample_if.sink),
    .cfg_i    (cfg_if.sink),
    .result_o (result_if.source)
  );

  axis_percent_checker percent_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .sample_valid_i (sample_if.valid),
    .sample_ready_i (sample_if.ready),
    .raw_sample_i   (sample_if.raw_sample),
    .cfg_valid_i    (cfg_if.valid),
    .cfg_ready_i    (cfg_if.ready),
    .cfg_index_i    (cfg_if.index),
    .cfg_data_i     (cfg_if.data),
    .result_valid_i (result_if.valid),
    .result_ready_i (result_if.ready),
    .axis_percent_i (result_if.axis_percent),
    .pending_o      (pending),
    .fail_count_o   (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("stick_axis_deadzone_scaler test failed");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [ADC_W-1:0] pick_raw();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom_range(0, ADC_TOP);
      4, 5:       v = int'(cur_mid) + int'($urandom_range(0, 120)) - 60;
      6:          v = int'(cur_hi) + int'($urandom_range(0, 16)) - 8;
      7:          v = int'(cur_lo) + int'($urandom_range(0, 16)) - 8;
      8:          v = ($urandom_range(0, 1) != 0) ? ADC_TOP : 0;
      default:    v = int'(cur_mid) + int'($urandom_range(0, 800)) - 400;
    endcase
    if (v < 0) begin
      v = 0;
    end
    if (v > ADC_TOP) begin
      v = ADC_TOP;
    end
    return v[ADC_W-1:0];
  endfunction

  task automatic wait_idle();
    while (pending != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // leaves valid high so back-to-back writes need no second assignment in a step
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [ADC_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
  endtask

  task automatic set_calibration(input logic [ADC_W-1:0] lo, input logic [ADC_W-1:0] mid,
                                 input logic [ADC_W-1:0] hi, input logic [ADC_W-1:0] dz);
    logic [IDX_W-1:0] unused_idx;
    unused_idx = IDX_W'(sads_pkg::REG_DEADZONE + 1 + cal_count % UNUSED_INDEXES);
    wait_idle();
    write_reg(sads_pkg::REG_MINIMUM, lo);
    write_reg(unused_idx, ADC_W'($urandom_range(0, ADC_TOP)));
    write_reg(sads_pkg::REG_CENTER, mid);
    write_reg(sads_pkg::REG_MAXIMUM, hi);
    write_reg(sads_pkg::REG_DEADZONE, dz);
    cfg_if.valid <= 1'b0;
    cur_lo  = lo;
    cur_mid = mid;
    cur_hi  = hi;
    cal_count++;
  endtask

  task automatic send_sample(input logic [ADC_W-1:0] raw);
    int unsigned gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap != 0) begin
      sample_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_if.valid      <= 1'b1;
    sample_if.raw_sample <= raw;
    do @(posedge clk); while (!sample_if.ready);
    @(negedge clk);
  endtask

  task automatic play_burst();
    foreach (burst_raws[i]) begin
      send_sample(burst_raws[i]);
    end
    sample_if.valid <= 1'b0;
  endtask

  initial begin
    int unsigned hold;
    result_if.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (long_hold) begin
        result_if.ready <= 1'b0;
        hold = LONG_HOLD_CYCLES;
        long_hold = 1'b0;
      end else if (rx_steady) begin
        result_if.ready <= 1'b1;
        hold = 1;
      end else if ($urandom_range(0, 2) != 0) begin
        result_if.ready <= 1'b1;
        hold = $urandom_range(1, 12);
      end else begin
        result_if.ready <= 1'b0;
        hold = pick_gap() + 1;
      end
      repeat (hold) @(negedge clk);
    end
  end

  initial begin
    logic [ADC_W-1:0] lo;
    logic [ADC_W-1:0] mid;
    logic [ADC_W-1:0] hi;
    logic [ADC_W-1:0] dz;
    rst_n                = 1'b0;
    sample_if.valid      = 1'b0;
    sample_if.raw_sample = '0;
    cfg_if.valid         = 1'b0;
    cfg_if.index         = sads_pkg::REG_MINIMUM;
    cfg_if.data          = '0;
    long_hold            = 1'b0;
    rx_steady            = 1'b0;
    tx_steady            = 1'b0;
    cal_count            = 0;
    cur_lo               = '0;
    cur_mid              = ADC_W'(2048);
    cur_hi               = '1;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // calibration after reset, full scale and center
    burst_raws = '{0, 4095, 2048, 2047, 2049};
    play_burst();
    // half-way rounding and samples beyond calibration
    set_calibration(1800, 2000, 2200, 0);
    burst_raws = '{2001, 1999, 2003, 0, 4095};
    play_burst();
    // deadzone edges on both sides
    set_calibration(0, 2000, 4000, 10);
    burst_raws = '{2400, 2401, 1600, 1599};
    play_burst();
    // degenerate calibrations
    set_calibration(2000, 2000, 4095, 0);
    burst_raws = '{0, 4095};
    play_burst();
    set_calibration(0, 2000, 1000, 0);
    burst_raws = '{0, 4095};
    play_burst();
    // oversized deadzone write, masked to 127
    set_calibration(0, 2048, 4095, 12'hFFF);
    burst_raws = '{0, 4095};
    play_burst();
    // center one above minimum
    set_calibration(0, 1, 4095, 0);
    burst_raws = '{0, 4095, 2};
    play_burst();

    for (int ph = 0; ph < PHASES; ph++) begin
      case ($urandom_range(0, 5))
        0: begin
          lo  = ADC_W'($urandom_range(0, ADC_TOP));
          mid = ADC_W'($urandom_range(0, ADC_TOP));
          hi  = ADC_W'($urandom_range(0, ADC_TOP));
        end
        1: begin
          lo = '0;
          hi = '1;
          case ($urandom_range(0, 2))
            0:       mid = ADC_W'(1);
            1:       mid = ADC_W'(2048);
            default: mid = ADC_W'(ADC_TOP - 1);
          endcase
        end
        default: begin
          lo  = ADC_W'($urandom_range(0, 1500));
          mid = ADC_W'(int'(lo) + 1 + int'($urandom_range(0, 1500)));
          hi  = ADC_W'($urandom_range(int'(mid) + 1, ADC_TOP));
        end
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: dz = ADC_W'($urandom_range(0, 30));
        6:                dz = ADC_W'(100);
        7:                dz = ADC_W'($urandom_range(0, 127));
        default:          dz = ADC_W'($urandom_range(0, ADC_TOP));
      endcase
      set_calibration(lo, mid, hi, dz);
      tx_steady = (ph == 1) || (ph == 4);
      rx_steady = (ph == 1);
      long_hold = (ph == 4);
      burst_raws.delete();
      repeat (PHASE_ITEMS) burst_raws.push_back(pick_raw());
      play_burst();
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("stick_axis_deadzone_scaler test passed");
    end else begin
      $display("stick_axis_deadzone_scaler test failed");
    end
    $finish;
  end

endmodule
